// ===== rtl/nsc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsc_pkg
// Shared constants, codes and types of the NMEA sentence checker.
// ---------------------------------------------------------------------------
package nsc_pkg;

  // Line framing
  localparam int unsigned LINE_LIMIT = 82;
  localparam int unsigned CNT_W      = 7;

  // End-of-line queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned QA_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned QC_W    = $clog2(Q_DEPTH + 1);

  // Characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Header words (talker + sentence id), first character highest
  localparam logic [39:0] HDR_GPRMC = {"GP", "RMC"};
  localparam logic [39:0] HDR_GPGGA = {"GP", "GGA"};
  localparam logic [39:0] HDR_GPGSA = {"GP", "GSA"};
  localparam logic [39:0] HDR_GPGSV = {"GP", "GSV"};
  localparam logic [39:0] HDR_GPHDT = {"GP", "HDT"};
  localparam logic [39:0] HDR_SDDPT = {"SD", "DPT"};

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_DOLLAR = 3'd1;
  localparam logic [2:0] ST_NO_STAR  = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;

  // Sentence type codes
  localparam logic [2:0] TY_OTHER = 3'd0;
  localparam logic [2:0] TY_GPRMC = 3'd1;
  localparam logic [2:0] TY_GPGGA = 3'd2;
  localparam logic [2:0] TY_GPGSA = 3'd3;
  localparam logic [2:0] TY_GPGSV = 3'd4;
  localparam logic [2:0] TY_GPHDT = 3'd5;
  localparam logic [2:0] TY_SDDPT = 3'd6;

  // Snapshot of a line's state, taken when its CR LF completes
  typedef struct packed {
    logic              too_long;
    logic              bad_start;
    logic              star_seen;
    logic              digits_done;
    logic [7:0]        xor_sum;
    logic [15:0]       hex_digits;
    logic [39:0]       header;
    logic [CNT_W-1:0]  length;
  } line_rec_t;

  // Upper-case ASCII hex character of a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ext;
    ext = {4'b0000, nib};
    if (nib < 4'd10) return 8'h30 + ext;
    else             return 8'h37 + ext;
  endfunction

endpackage

// ===== rtl/nsc_in_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsc_in_if
// Byte channel into the checker: valid/ready handshake with one character.
// ---------------------------------------------------------------------------
interface nsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/nsc_out_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsc_out_if
// Result channel: one record per framed line, valid/ready handshake.
// ---------------------------------------------------------------------------
interface nsc_out_if;
  logic                      valid;
  logic                      ready;
  logic [2:0]                status;
  logic [2:0]                sentence_type;
  logic [7:0]                computed_checksum;
  logic [nsc_pkg::CNT_W-1:0] line_length;

  modport source (output valid, output status, output sentence_type,
                  output computed_checksum, output line_length, input ready);
  modport sink   (input valid, input status, input sentence_type,
                  input computed_checksum, input line_length, output ready);
endinterface

// ===== rtl/nsc_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsc_front
// Per-byte framing: running XOR, header capture, checksum digits and line
// length. Emits a line snapshot on each CR LF.
// ---------------------------------------------------------------------------
module nsc_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [7:0]            in_byte,
  output logic                  in_ready,
  input  logic                  q_ready,
  output logic                  q_push,
  output nsc_pkg::line_rec_t    q_rec
);

  typedef enum logic [4:0] {
    PH_START = 5'b00001,
    PH_BODY  = 5'b00010,
    PH_HEX1  = 5'b00100,
    PH_HEX2  = 5'b01000,
    PH_TAIL  = 5'b10000
  } phase_t;

  localparam logic [nsc_pkg::CNT_W-1:0] LIMIT    = nsc_pkg::CNT_W'(nsc_pkg::LINE_LIMIT);
  localparam logic [nsc_pkg::CNT_W-1:0] HDR_FIRST = nsc_pkg::CNT_W'(1);
  localparam logic [nsc_pkg::CNT_W-1:0] HDR_LAST  = nsc_pkg::CNT_W'(5);

  phase_t                     phase_r, phase_nxt;
  logic [7:0]                 xor_r, xor_nxt;
  logic [nsc_pkg::CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic [39:0]                hdr_r, hdr_nxt;
  logic [15:0]                hex_r, hex_nxt;
  logic                       bad_start_r, bad_start_nxt;
  logic                       too_long_r, too_long_nxt;
  logic                       star_r, star_nxt;
  logic                       cr_r, cr_nxt;
  logic                       take, sat, eol;

  assign in_ready = q_ready;
  assign take     = in_valid && in_ready;
  assign sat      = (cnt_r >= LIMIT);
  assign cnt_inc  = sat ? cnt_r : cnt_r + 1'b1;
  assign eol      = (in_byte == nsc_pkg::CH_LF) && cr_r;
  assign q_push   = take && eol;

  always_comb begin
    q_rec.too_long    = too_long_r | sat;
    q_rec.bad_start   = bad_start_r;
    q_rec.star_seen   = star_r;
    q_rec.digits_done = (phase_r == PH_TAIL);
    q_rec.xor_sum     = xor_r;
    q_rec.hex_digits  = hex_r;
    q_rec.header      = hdr_r;
    q_rec.length      = cnt_inc;
  end

  always_comb begin
    phase_nxt     = phase_r;
    xor_nxt       = xor_r;
    cnt_nxt       = cnt_r;
    hdr_nxt       = hdr_r;
    hex_nxt       = hex_r;
    bad_start_nxt = bad_start_r;
    too_long_nxt  = too_long_r;
    star_nxt      = star_r;
    cr_nxt        = cr_r;
    if (take) begin
      if (eol) begin
        // line done: snapshot goes to the queue, start afresh
        phase_nxt     = PH_START;
        xor_nxt       = '0;
        cnt_nxt       = '0;
        hdr_nxt       = '0;
        hex_nxt       = '0;
        bad_start_nxt = 1'b0;
        too_long_nxt  = 1'b0;
        star_nxt      = 1'b0;
        cr_nxt        = 1'b0;
      end else begin
        cnt_nxt      = cnt_inc;
        too_long_nxt = too_long_r | sat;
        if (cnt_r >= HDR_FIRST && cnt_r <= HDR_LAST) hdr_nxt = {hdr_r[31:0], in_byte};
        unique case (phase_r)
          PH_START: begin
            bad_start_nxt = (in_byte != nsc_pkg::CH_DOLLAR);
            phase_nxt     = PH_BODY;
          end
          PH_BODY: begin
            if (in_byte == nsc_pkg::CH_STAR) begin
              star_nxt  = 1'b1;
              phase_nxt = PH_HEX1;
            end else begin
              xor_nxt = xor_r ^ in_byte;
            end
          end
          PH_HEX1: begin
            hex_nxt   = {in_byte, 8'h00};
            phase_nxt = PH_HEX2;
          end
          PH_HEX2: begin
            hex_nxt   = {hex_r[15:8], in_byte};
            phase_nxt = PH_TAIL;
          end
          PH_TAIL: ;
          default: phase_nxt = PH_START;
        endcase
        cr_nxt = (in_byte == nsc_pkg::CH_CR);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      xor_r       <= '0;
      cnt_r       <= '0;
      hdr_r       <= '0;
      hex_r       <= '0;
      bad_start_r <= 1'b0;
      too_long_r  <= 1'b0;
      star_r      <= 1'b0;
      cr_r        <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      xor_r       <= xor_nxt;
      cnt_r       <= cnt_nxt;
      hdr_r       <= hdr_nxt;
      hex_r       <= hex_nxt;
      bad_start_r <= bad_start_nxt;
      too_long_r  <= too_long_nxt;
      star_r      <= star_nxt;
      cr_r        <= cr_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LIMIT) else $error("line count beyond limit");
  a_star_phase: assert property (@(posedge clk) disable iff (!rst_n)
    star_r |-> (phase_r != PH_START && phase_r != PH_BODY))
    else $error("asterisk flagged but still in body");
`endif

endmodule

// ===== rtl/nsc_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsc_queue
// Short FIFO of line snapshots between the framing front and the result back.
// ---------------------------------------------------------------------------
module nsc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  nsc_pkg::line_rec_t  push_rec,
  output logic                not_full,
  input  logic                pop,
  output logic                head_valid,
  output nsc_pkg::line_rec_t  head_rec
);

  localparam logic [nsc_pkg::QA_W-1:0] LAST_SLOT = nsc_pkg::QA_W'(nsc_pkg::Q_DEPTH - 1);
  localparam logic [nsc_pkg::QC_W-1:0] FULL_CNT  = nsc_pkg::QC_W'(nsc_pkg::Q_DEPTH);

  nsc_pkg::line_rec_t          slot_r [nsc_pkg::Q_DEPTH];
  logic [nsc_pkg::QA_W-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [nsc_pkg::QC_W-1:0]    cnt_r, cnt_nxt;

  assign not_full   = (cnt_r != FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head_rec   = slot_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (wr_r == LAST_SLOT) ? '0 : wr_r + 1'b1;
    if (pop)  rd_nxt = (rd_r == LAST_SLOT) ? '0 : rd_r + 1'b1;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_rec;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> not_full) else $error("transfer into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("pop from empty queue");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT) else $error("queue count beyond depth");
`endif

endmodule

// ===== rtl/nsc_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsc_back
// Turns a line snapshot into status, sentence type and checksum, and holds
// the result in the output register until transferred.
// ---------------------------------------------------------------------------
module nsc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  nsc_pkg::line_rec_t         q_rec,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_status,
  output logic [2:0]                 out_type,
  output logic [7:0]                 out_sum,
  output logic [nsc_pkg::CNT_W-1:0]  out_len
);

  logic                       valid_r;
  logic [2:0]                 status_r, status_nxt;
  logic [2:0]                 type_r, type_nxt;
  logic [7:0]                 sum_r, sum_nxt;
  logic [nsc_pkg::CNT_W-1:0]  len_r;
  logic [15:0]                want;

  assign q_pop = q_valid && (!valid_r || out_ready);
  assign want  = {nsc_pkg::hex_char(q_rec.xor_sum[7:4]),
                  nsc_pkg::hex_char(q_rec.xor_sum[3:0])};

  always_comb begin
    priority if (q_rec.too_long)                              status_nxt = nsc_pkg::ST_TOO_LONG;
    else if (q_rec.bad_start)                                 status_nxt = nsc_pkg::ST_NO_DOLLAR;
    else if (!q_rec.star_seen)                                status_nxt = nsc_pkg::ST_NO_STAR;
    else if (!q_rec.digits_done || q_rec.hex_digits != want) status_nxt = nsc_pkg::ST_MISMATCH;
    else                                                      status_nxt = nsc_pkg::ST_OK;

    type_nxt = nsc_pkg::TY_OTHER;
    if (status_nxt == nsc_pkg::ST_OK) begin
      priority case (q_rec.header)
        nsc_pkg::HDR_GPRMC: type_nxt = nsc_pkg::TY_GPRMC;
        nsc_pkg::HDR_GPGGA: type_nxt = nsc_pkg::TY_GPGGA;
        nsc_pkg::HDR_GPGSA: type_nxt = nsc_pkg::TY_GPGSA;
        nsc_pkg::HDR_GPGSV: type_nxt = nsc_pkg::TY_GPGSV;
        nsc_pkg::HDR_GPHDT: type_nxt = nsc_pkg::TY_GPHDT;
        nsc_pkg::HDR_SDDPT: type_nxt = nsc_pkg::TY_SDDPT;
        default:            type_nxt = nsc_pkg::TY_OTHER;
      endcase
    end

    // checksum only reported when the line got as far as the asterisk
    if (status_nxt == nsc_pkg::ST_OK || status_nxt == nsc_pkg::ST_MISMATCH)
      sum_nxt = q_rec.xor_sum;
    else
      sum_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r <= status_nxt;
      type_r   <= type_nxt;
      sum_r    <= sum_nxt;
      len_r    <= q_rec.length;
    end
  end

  assign out_valid  = valid_r;
  assign out_status = status_r;
  assign out_type   = type_r;
  assign out_sum    = sum_r;
  assign out_len    = len_r;

`ifndef ASSERT_OFF
  a_type_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && status_r != nsc_pkg::ST_OK) |-> (type_r == nsc_pkg::TY_OTHER))
    else $error("sentence type reported on a failed line");
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (len_r <= nsc_pkg::CNT_W'(nsc_pkg::LINE_LIMIT)))
    else $error("line length beyond limit");
`endif

endmodule

// ===== rtl/nsc_pkg_unused_guard.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsc_len_guard
// Flags a queued line snapshot whose length cannot be a framed line: every
// snapshot closes on CR LF, so it is at least two bytes long.
// ---------------------------------------------------------------------------
module nsc_len_guard (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  nsc_pkg::line_rec_t  push_rec,
  output logic                short_line
);

  localparam logic [nsc_pkg::CNT_W-1:0] MIN_LEN = nsc_pkg::CNT_W'(2);

  logic short_r;

  always_ff @(posedge clk) begin
    if (!rst_n) short_r <= 1'b0;
    else        short_r <= push && (push_rec.length < MIN_LEN);
  end

  assign short_line = short_r;

`ifndef ASSERT_OFF
  a_min_len: assert property (@(posedge clk) disable iff (!rst_n)
    !short_r) else $error("line shorter than CR LF queued");
`endif

endmodule

// ===== rtl/nmea_sentence_checker_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nmea_sentence_checker_unit
// NMEA 0183 line framer and checksum checker, one result per CR LF line.
// ---------------------------------------------------------------------------
// One received byte is taken every clock cycle unless the input stalls. The
// snapshot of a line enters the queue on the transfer of its terminating LF,
// and its result is loaded into the result register once that is free.
// The framing front runs a running XOR and a phase tracker; line
// snapshots pass through a two-entry queue to the result stage, so the input
// stalls only when two finished lines are still waiting behind a held result.
// Status: 0 ok, 1 no leading dollar, 2 no asterisk, 3 checksum mismatch,
// 4 line longer than the limit (length saturates at the limit).
module nmea_sentence_checker_unit (
  input  logic             clk,
  input  logic             rst_n,
  nsc_in_if.sink           in_ch,
  nsc_out_if.source        out_ch
);

  nsc_pkg::line_rec_t push_rec, head_rec;
  logic               push, not_full, pop, head_valid, short_line;

  nsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_byte  (in_ch.rx_byte),
    .in_ready (in_ch.ready),
    .q_ready  (not_full),
    .q_push   (push),
    .q_rec    (push_rec)
  );

  nsc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_rec   (push_rec),
    .not_full   (not_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  nsc_len_guard u_guard (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_rec   (push_rec),
    .short_line (short_line)
  );

  nsc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (head_valid && !short_line) ,
    .q_rec      (head_rec),
    .q_pop      (pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_type   (out_ch.sentence_type),
    .out_sum    (out_ch.computed_checksum),
    .out_len    (out_ch.line_length)
  );

endmodule

// ===== test/nmea_sentence_checker_unit_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nmea_sentence_checker_unit_tb
// Self-checking bench for the NMEA line checker. A byte stream of directed
// and random sentences is pushed through the input channel in bursts, while
// the result channel stalls on its own pattern. A scoreboard class tracks
// line state per accepted byte and compares every result with its forecast.
// ---------------------------------------------------------------------------
module nmea_sentence_checker_unit_tb;

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_BODY,
    PH_HEX_HI,
    PH_HEX_LO,
    PH_TAIL
  } scan_phase_e;

  typedef enum int unsigned {
    FORM_GOOD,
    FORM_BAD_DIGIT,
    FORM_LOWER,
    FORM_SHORT,
    FORM_NO_STAR,
    FORM_NO_DOLLAR
  } line_form_e;

  typedef struct packed {
    logic [2:0]                status;
    logic [2:0]                sentence;
    logic [7:0]                checksum;
    logic [nsc_pkg::CNT_W-1:0] length;
  } line_result_t;

  typedef logic [7:0] byte_q_t[$];

  class line_scoreboard;
    scan_phase_e               phase;
    logic [7:0]                xor_acc;
    logic [nsc_pkg::CNT_W-1:0] count;
    logic [39:0]               header;
    logic [15:0]               digits;
    bit                        bad_start, too_long, star_seen, last_cr;
    line_result_t              expected_q[$];
    int unsigned               errors, results, bytes_seen;
    int unsigned               status_tally[5];

    function new();
      clear_line();
    endfunction

    function void clear_line();
      phase     = PH_FIRST;
      xor_acc   = '0;
      count     = '0;
      header    = '0;
      digits    = '0;
      bad_start = 0;
      too_long  = 0;
      star_seen = 0;
      last_cr   = 0;
    endfunction

    static function logic [7:0] hex_ascii(logic [3:0] n);
      return (n < 4'd10) ? ("0" + {4'h0, n}) : ("A" - 8'd10 + {4'h0, n});
    endfunction

    function logic [2:0] header_kind();
      case (header)
        nsc_pkg::HDR_GPRMC: return nsc_pkg::TY_GPRMC;
        nsc_pkg::HDR_GPGGA: return nsc_pkg::TY_GPGGA;
        nsc_pkg::HDR_GPGSA: return nsc_pkg::TY_GPGSA;
        nsc_pkg::HDR_GPGSV: return nsc_pkg::TY_GPGSV;
        nsc_pkg::HDR_GPHDT: return nsc_pkg::TY_GPHDT;
        nsc_pkg::HDR_SDDPT: return nsc_pkg::TY_SDDPT;
        default:            return nsc_pkg::TY_OTHER;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // One accepted byte; a CR LF closes the line and forecasts its result
    function void note_byte(logic [7:0] b);
      logic [nsc_pkg::CNT_W-1:0] pos;
      logic [15:0]               want;
      line_result_t              r;
      bytes_seen++;
      pos = count;
      if (count >= nsc_pkg::CNT_W'(nsc_pkg::LINE_LIMIT)) begin
        too_long = 1;
        count    = nsc_pkg::CNT_W'(nsc_pkg::LINE_LIMIT);
      end else begin
        count++;
      end
      if (b == nsc_pkg::CH_LF && last_cr) begin
        want = {hex_ascii(xor_acc[7:4]), hex_ascii(xor_acc[3:0])};
        if (too_long)                                r.status = nsc_pkg::ST_TOO_LONG;
        else if (bad_start)                          r.status = nsc_pkg::ST_NO_DOLLAR;
        else if (!star_seen)                         r.status = nsc_pkg::ST_NO_STAR;
        else if (phase != PH_TAIL || digits != want) r.status = nsc_pkg::ST_MISMATCH;
        else                                         r.status = nsc_pkg::ST_OK;
        r.sentence = (r.status == nsc_pkg::ST_OK) ? header_kind() : nsc_pkg::TY_OTHER;
        r.checksum = (r.status == nsc_pkg::ST_OK || r.status == nsc_pkg::ST_MISMATCH) ?
                     xor_acc : 8'h00;
        r.length   = count;
        expected_q = {expected_q, r};
        clear_line();
        return;
      end
      if (pos >= 1 && pos <= 5) header = {header[31:0], b};
      case (phase)
        PH_FIRST: begin
          bad_start = (b != nsc_pkg::CH_DOLLAR);
          phase     = PH_BODY;
        end
        PH_BODY: begin
          if (b == nsc_pkg::CH_STAR) begin
            star_seen = 1;
            phase     = PH_HEX_HI;
          end else begin
            xor_acc ^= b;
          end
        end
        PH_HEX_HI: begin
          digits = {b, 8'h00};
          phase  = PH_HEX_LO;
        end
        PH_HEX_LO: begin
          digits[7:0] = b;
          phase       = PH_TAIL;
        end
        default: ;
      endcase
      last_cr = (b == nsc_pkg::CH_CR);
    endfunction

    function void check_result(line_result_t got);
      line_result_t want_r;
      results++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("[%0t] unexpected result: status %0d type %0d checksum %02h length %0d",
                   $realtime, got.status, got.sentence, got.checksum, got.length);
        return;
      end
      want_r = expected_q.pop_front();
      if (want_r.status < 5) status_tally[want_r.status]++;
      if (got !== want_r) begin
        errors++;
        if (errors <= 10)
          $display({"[%0t] line %0d mismatch (exp/act): status %0d/%0d type %0d/%0d ",
                    "checksum %02h/%02h length %0d/%0d"}, $realtime, results,
                   want_r.status, got.status, want_r.sentence, got.sentence,
                   want_r.checksum, got.checksum, want_r.length, got.length);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  nsc_in_if  in_ch ();
  nsc_out_if out_ch ();

  nmea_sentence_checker_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  line_scoreboard sb;
  logic [7:0]     tx_stream[$];

  // --- stream building -----------------------------------------------------

  function automatic byte_q_t to_bytes(string s);
    byte_q_t q;
    foreach (s[i]) q = {q, 8'(s[i])};
    return q;
  endfunction

  // Content byte: never lets a CR LF end the line early; stars only on request
  function automatic logic [7:0] push_content(logic [7:0] b, bit keep_star);
    if (b == nsc_pkg::CH_STAR && !keep_star) b = ",";
    if (b == nsc_pkg::CH_LF && tx_stream.size() > 0 && tx_stream[$] == nsc_pkg::CH_CR)
      b = 8'h0B;
    tx_stream = {tx_stream, b};
    return b;
  endfunction

  function automatic void push_eol();
    tx_stream = {tx_stream, nsc_pkg::CH_CR, nsc_pkg::CH_LF};
  endfunction

  function automatic void add_raw(string s);
    foreach (s[i]) tx_stream = {tx_stream, 8'(s[i])};
    push_eol();
  endfunction

  function automatic void add_sentence(byte_q_t body, line_form_e form, bit tail);
    logic [7:0] sum, hi, lo, lead;
    sum = '0;
    if (form == FORM_NO_DOLLAR) begin
      lead = 8'($urandom_range(0, 255));
      if (lead == nsc_pkg::CH_DOLLAR) lead = "!";
      void'(push_content(lead, 0));
    end else begin
      tx_stream = {tx_stream, nsc_pkg::CH_DOLLAR};
    end
    foreach (body[i]) sum ^= push_content(body[i], 0);
    if (form == FORM_NO_STAR) begin
      push_eol();
      return;
    end
    tx_stream = {tx_stream, nsc_pkg::CH_STAR};
    hi = line_scoreboard::hex_ascii(sum[7:4]);
    lo = line_scoreboard::hex_ascii(sum[3:0]);
    case (form)
      FORM_BAD_DIGIT: tx_stream = {tx_stream, hi, lo ^ 8'h01};
      FORM_LOWER:     tx_stream = {tx_stream, hi | 8'h20, lo | 8'h20};
      FORM_SHORT:     if ($urandom_range(0, 1)) tx_stream = {tx_stream, hi};
      default:        tx_stream = {tx_stream, hi, lo};
    endcase
    if (tail) repeat ($urandom_range(1, 6)) void'(push_content(8'($urandom_range(0, 255)), 1));
    push_eol();
  endfunction

  function automatic void add_random_line();
    string       known[6] = '{"GPRMC", "GPGGA", "GPGSA", "GPGSV", "GPHDT", "SDDPT"};
    byte_q_t     body;
    int unsigned pick, len;
    line_form_e  form;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      // noise: any bytes, framing characters favoured
      repeat ($urandom_range(0, 30)) begin
        case ($urandom_range(0, 5))
          0:       void'(push_content(nsc_pkg::CH_CR, 1));
          1:       void'(push_content(nsc_pkg::CH_LF, 1));
          2:       void'(push_content(nsc_pkg::CH_STAR, 1));
          3:       void'(push_content(nsc_pkg::CH_DOLLAR, 1));
          default: void'(push_content(8'($urandom_range(0, 255)), 1));
        endcase
      end
      push_eol();
      return;
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: body = to_bytes(known[$urandom_range(0, 5)]);
      6: begin
        body = to_bytes(known[$urandom_range(0, 5)]);
        body[$urandom_range(0, 4)] += 8'd1;
      end
      7: repeat ($urandom_range(0, 5)) body = {body, 8'($urandom_range(0, 255))};
      default: begin
        body = to_bytes("GP");
        repeat (3) body = {body, 8'($urandom_range("A", "Z"))};
      end
    endcase
    body = {body, 8'(",")};
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 90) : $urandom_range(0, 30);
    repeat (len)
      body = {body, ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(32, 126))};
    if (pick < 72)      form = FORM_GOOD;
    else if (pick < 80) form = FORM_BAD_DIGIT;
    else if (pick < 85) form = FORM_LOWER;
    else if (pick < 90) form = FORM_SHORT;
    else if (pick < 94) form = FORM_NO_STAR;
    else                form = FORM_NO_DOLLAR;
    add_sentence(body, form, $urandom_range(0, 4) == 0);
  endfunction

  function automatic void add_directed_lines();
    byte_q_t q;
    add_sentence(to_bytes("GPRMC,123519,A,4807.038,N"), FORM_GOOD, 0);
    add_sentence(to_bytes("GPGGA,092750.000,5321.6802"), FORM_GOOD, 0);
    add_sentence(to_bytes("GPGSA,A,3,10,07,05"), FORM_GOOD, 0);
    add_sentence(to_bytes("GPGSV,3,1,11"), FORM_GOOD, 0);
    add_sentence(to_bytes("GPHDT,274.07,T"), FORM_GOOD, 0);
    add_sentence(to_bytes("SDDPT,12.4,0.5"), FORM_GOOD, 0);
    add_sentence(to_bytes("GPXYZ,1"), FORM_GOOD, 0);
    add_sentence(to_bytes("GP"), FORM_GOOD, 0);          // header cut short
    add_sentence(to_bytes(""), FORM_GOOD, 0);
    add_sentence(to_bytes("GPGGA,9"), FORM_BAD_DIGIT, 0);
    add_sentence(to_bytes("GPRMC,zz"), FORM_LOWER, 0);
    add_sentence(to_bytes("GPGSA,1"), FORM_SHORT, 0);
    add_raw("$GPGSV*");                                  // CR taken as a digit
    add_sentence(to_bytes("GPRMC,1"), FORM_NO_STAR, 0);
    add_sentence(to_bytes("GPHDT,2"), FORM_NO_DOLLAR, 0);
    add_raw("");                                         // bare CR LF
    add_raw("$");
    add_sentence(to_bytes("GP\nRMC,4"), FORM_GOOD, 0);   // lone LF inside
    add_sentence(to_bytes("GPGGA,AB\rCD"), FORM_GOOD, 0);
    add_sentence(to_bytes("GPHDT,5"), FORM_GOOD, 1);     // junk after the digits
    add_raw("$GP*4*12");
    q = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA};
    add_sentence(q, FORM_GOOD, 0);
    // 76, 77 and 120 body bytes: exactly at, one over and well over the limit
    q = '{};
    repeat (76) q = {q, 8'($urandom_range("0", "9"))};
    add_sentence(q, FORM_GOOD, 0);
    q = {q, 8'("7")};
    add_sentence(q, FORM_GOOD, 0);
    repeat (43) q = {q, 8'($urandom_range(0, 255))};
    add_sentence(q, FORM_GOOD, 0);
  endfunction

  // --- drivers -------------------------------------------------------------

  task automatic send_byte(logic [7:0] b);
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic idle_cycles(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_ch.valid   <= 1'b0;
      in_ch.rx_byte <= 8'($urandom_range(0, 255));
    end
  endtask

  // receiver: switches at random between stall habits
  initial begin
    logic [7:0]  mask;
    int unsigned mode, k;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      mask = 8'($urandom_range(1, 255));
      k    = 0;
      repeat ($urandom_range(20, 80)) begin
        @(negedge clk);
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= mask[k[2:0]];
          default: out_ch.ready <= ($urandom_range(0, 9) == 0);
        endcase
        k++;
      end
    end
  end

  always @(posedge clk) begin
    line_result_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.status   = out_ch.status;
        got.sentence = out_ch.sentence_type;
        got.checksum = out_ch.computed_checksum;
        got.length   = out_ch.line_length;
        sb.check_result(got);
      end
      if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.rx_byte);
    end
  end

  initial begin
    #(5_000_000);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned burst;
    sb            = new();
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    add_directed_lines();
    while (tx_stream.size() < 1950) add_random_line();

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (tx_stream.size() > 0) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 40);
      while (burst > 0 && tx_stream.size() > 0) begin
        send_byte(tx_stream.pop_front());
        burst--;
      end
      idle_cycles(($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 6));
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes, %0d line results checked: ok %0d, no dollar %0d, no star %0d,",
             sb.bytes_seen, sb.results, sb.status_tally[nsc_pkg::ST_OK],
             sb.status_tally[nsc_pkg::ST_NO_DOLLAR], sb.status_tally[nsc_pkg::ST_NO_STAR]);
    $display("  checksum mismatch %0d, too long %0d; %0d errors",
             sb.status_tally[nsc_pkg::ST_MISMATCH], sb.status_tally[nsc_pkg::ST_TOO_LONG],
             sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/nsc_pkg.sv
rtl/nsc_in_if.sv
rtl/nsc_out_if.sv
rtl/nsc_front.sv
rtl/nsc_queue.sv
rtl/nsc_back.sv
rtl/nsc_pkg_unused_guard.sv
rtl/nmea_sentence_checker_unit.sv
test/nmea_sentence_checker_unit_tb.sv
